@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the hash table block.
// Depends on nothing; the using module must provide aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/core/lpht_pkg.sv @@
// Types, codes and constants of the linear probing hash table.
// Used by the top level and by its checker; depends on nothing.
package lpht_pkg;

    // Field widths of the requests and results.
    localparam int KEY_W      = 31;
    localparam int HANDLE_W   = 32;
    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_W      = 5;

    // Default table size and reset value of the slot count register.
    localparam int              TABLE_SLOTS_DEF = 16;
    localparam logic [CFG_W-1:0] CFG_RESET      = 5'd11;

    // The remainder unit retires two dividend bits per cycle.
    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd5;

    // Slot marks.
    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_COMMIT
    } state_t;

endpackage

@@ rtl/core/linear_probe_hash_table.sv @@
// Open-addressing hash table with linear probing, keyed by a 31-bit identifier.
// Depends on lpht_pkg for codes, widths and the sequencer state type.
//
//  Channel  Direction  Handshake              Contents
//  s_       in         s_tvalid / s_tready    tuser: opcode; tdata: key, record_handle
//  m_       out        m_tvalid / m_tready    tuser: status; tdata: found_handle, slot_index
//  cfg_     in         cfg_valid / cfg_ready  data: slots_in_use
//
// A request passes from acceptance to its result through the two-bit-per-cycle remainder
// unit, then probes at least one and at most all of the slots in use, each slot read through
// the registered slot memory and then compared, and then commits. The block takes one request
// at a time and is ready again once it commits.
// Reset clears the slot marks at once; keys and handles are not cleared.
// A result waits in the output register; commit holds until that register is free.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Request channel.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [63:0]             s_tdata,    // [30:0] key, [62:31] record_handle
    input  logic [OPCODE_W-1:0]     s_tuser,    // [1:0] opcode
    // Result channel.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [39:0]             m_tdata,    // [31:0] found_handle, [35:32] slot_index
    output logic [STATUS_W-1:0]     m_tuser,    // [2:0] status
    // Configuration channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data    // [4:0] slots_in_use
);

    // The slot count register cannot select more slots than it can count.
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int DEPTH   = (TABLE_SLOTS < CFG_MAX) ? TABLE_SLOTS : CFG_MAX;
    localparam int PW      = $clog2(DEPTH);

    // Storage.
    logic [KEY_W-1:0]    key_mem [DEPTH];
    logic [HANDLE_W-1:0] hdl_mem [DEPTH];
    mark_t               marks_reg [DEPTH];

    // Control and payload registers.
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    cfg_slots_reg;
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] hdl_reg, hdl_next;
    logic [DIV_W-1:0]    dvd_reg, dvd_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PW-1:0]       h_reg, h_next;
    logic [CFG_W-1:0]    issued_reg, issued_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                cmp_last_reg, cmp_last_next;
    logic [PW-1:0]       cmp_slot_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [HANDLE_W-1:0] rd_hdl_reg;
    logic                free_valid_reg, free_valid_next;
    logic [PW-1:0]       free_slot_reg, free_slot_next;
    logic                hit_reg, hit_next;
    logic [PW-1:0]       hit_slot_reg, hit_slot_next;
    logic [HANDLE_W-1:0] hit_hdl_reg, hit_hdl_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [HANDLE_W-1:0] m_hdl_reg, m_hdl_next;
    logic [SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;

    // Write strobes for the stores.
    logic                mem_we;
    logic                mark_we;
    logic [PW-1:0]       mark_wa;
    mark_t               mark_wd;

    // Shared datapath signals.
    logic [CFG_W-1:0]    n_act;
    logic [CFG_W:0]      t1, t2, r1, r2;
    logic [CFG_W-1:0]    h_inc;
    mark_t               cmp_mark;
    logic                is_empty, is_match;

    // Clamp the configured slot count into 1..DEPTH.
    always_comb begin
        if (cfg_slots_reg == '0) begin
            n_act = CFG_W'(1);
        end else if (cfg_slots_reg > CFG_W'(DEPTH)) begin
            n_act = CFG_W'(DEPTH);
        end else begin
            n_act = cfg_slots_reg;
        end
    end

    // Remainder unit: two restoring steps per cycle against the slot count.
    always_comb begin
        t1 = {rem_reg, dvd_reg[DIV_W-1]};
        r1 = (t1 >= {1'b0, n_act}) ? t1 - {1'b0, n_act} : t1;
        t2 = {r1[CFG_W-1:0], dvd_reg[DIV_W-2]};
        r2 = (t2 >= {1'b0, n_act}) ? t2 - {1'b0, n_act} : t2;
    end

    // Probe pointer increment and the compare of the slot just read.
    assign h_inc    = CFG_W'(h_reg) + CFG_W'(1);
    assign cmp_mark = marks_reg[cmp_slot_reg];
    assign is_empty = (cmp_mark == MARK_EMPTY);
    assign is_match = (cmp_mark == MARK_USED) && (rd_key_reg == key_reg);

    // Handshake outputs.
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {4'b0, m_slot_reg, m_hdl_reg};

    // Sequencer: next state, datapath controls and the committed result.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        hdl_next        = hdl_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        h_next          = h_reg;
        issued_next     = issued_reg;
        cmp_valid_next  = 1'b0;
        cmp_last_next   = cmp_last_reg;
        free_valid_next = free_valid_reg;
        free_slot_next  = free_slot_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_hdl_next    = hit_hdl_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_hdl_next      = m_hdl_reg;
        m_slot_next     = m_slot_reg;
        mem_we          = 1'b0;
        mark_we         = 1'b0;
        mark_wa         = hit_slot_reg;
        mark_wd         = MARK_TOMB;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[KEY_W-1:0];
                    hdl_next   = s_tdata[KEY_W+HANDLE_W-1:KEY_W];
                    dvd_next   = {1'b0, s_tdata[KEY_W-1:0]};
                    rem_next   = '0;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    state_next = S_DIV;
                end
            end

            S_DIV: begin
                rem_next = r2[CFG_W-1:0];
                dvd_next = dvd_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    h_next          = r2[PW-1:0];
                    issued_next     = '0;
                    free_valid_next = 1'b0;
                    state_next      = S_PROBE;
                end
            end

            S_PROBE: begin
                // Issue the next read while the previous slot is compared.
                if (issued_reg < n_act) begin
                    issued_next    = issued_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_last_next  = (issued_reg == n_act - CFG_W'(1));
                    h_next         = (h_inc == n_act) ? '0 : PW'(h_inc);
                end
                if (cmp_valid_reg) begin
                    if (cmp_mark != MARK_USED && !free_valid_reg) begin
                        free_valid_next = 1'b1;
                        free_slot_next  = cmp_slot_reg;
                    end
                    if (is_match) begin
                        hit_next      = 1'b1;
                        hit_slot_next = cmp_slot_reg;
                        hit_hdl_next  = rd_hdl_reg;
                    end
                    if (is_empty || is_match || cmp_last_reg) begin
                        cmp_valid_next = 1'b0;
                        state_next     = S_COMMIT;
                    end
                end
            end

            S_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = STAT_NOT_FOUND;
                    m_hdl_next    = '0;
                    m_slot_next   = '0;
                    case (op_reg)
                        OP_INSERT: begin
                            if (hit_reg) begin
                                m_status_next = STAT_DUPLICATE;
                                m_slot_next   = SLOT_OUT_W'(hit_slot_reg);
                            end else if (free_valid_reg) begin
                                m_status_next = STAT_INSERTED;
                                m_slot_next   = SLOT_OUT_W'(free_slot_reg);
                                mem_we        = 1'b1;
                                mark_we       = 1'b1;
                                mark_wa       = free_slot_reg;
                                mark_wd       = MARK_USED;
                            end else begin
                                m_status_next = STAT_FULL;
                            end
                        end
                        OP_SEARCH: begin
                            if (hit_reg) begin
                                m_status_next = STAT_FOUND;
                                m_hdl_next    = hit_hdl_reg;
                                m_slot_next   = SLOT_OUT_W'(hit_slot_reg);
                            end
                        end
                        OP_DELETE: begin
                            if (hit_reg) begin
                                m_status_next = STAT_DELETED;
                                m_slot_next   = SLOT_OUT_W'(hit_slot_reg);
                                mark_we       = 1'b1;
                            end
                        end
                        default: begin
                            m_status_next = STAT_NOT_FOUND;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and the slot marks, set by reset; the slot count resets to CFG_RESET.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cfg_slots_reg <= CFG_RESET;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                marks_reg[i] <= MARK_EMPTY;
            end
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid) begin
                cfg_slots_reg <= cfg_data;
            end
            if (mark_we) begin
                marks_reg[mark_wa] <= mark_wd;
            end
        end
    end

    // Payload registers of the request, the probe and the result.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        hdl_reg        <= hdl_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        h_reg          <= h_next;
        issued_reg     <= issued_next;
        cmp_last_reg   <= cmp_last_next;
        cmp_slot_reg   <= h_reg;
        free_valid_reg <= free_valid_next;
        free_slot_reg  <= free_slot_next;
        hit_reg        <= hit_next;
        hit_slot_reg   <= hit_slot_next;
        hit_hdl_reg    <= hit_hdl_next;
        m_status_reg   <= m_status_next;
        m_hdl_reg      <= m_hdl_next;
        m_slot_reg     <= m_slot_next;
    end

    // Key and handle memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[free_slot_reg] <= key_reg;
            hdl_mem[free_slot_reg] <= hdl_reg;
        end
        rd_key_reg <= key_mem[h_reg];
        rd_hdl_reg <= hdl_mem[h_reg];
    end

endmodule

@@ rtl/core/lpht_checker.sv @@
// Port-level checker for the hash table, attached to the top level by a bind.
// Depends on lpht_pkg for status codes and on assert_macros.svh.
`include "assert_macros.svh"

module lpht_checker
    import lpht_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [39:0]         m_tdata,
    input  logic [STATUS_W-1:0] m_tuser
);

    // A stalled result keeps its contents.
    `ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Only a found result carries a handle.
    `ASSERT_CLK(a_handle, m_tvalid && (m_tuser != STAT_FOUND) |-> (m_tdata[31:0] == '0), "handle on a result that is not found")

    // Results that touch no slot report slot zero.
    `ASSERT_CLK(a_slot, m_tvalid && (m_tuser == STAT_NOT_FOUND || m_tuser == STAT_FULL) |-> (m_tdata[35:32] == '0), "slot index on a result without a slot")

    // Once a request is taken the block is busy in the next cycle.
    `ASSERT_CLK(a_busy, s_tvalid && s_tready |=> !s_tready, "ready again directly after a request")

    // Reset leaves no result pending.
    `ASSERT_ANY(a_reset, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the linear probing hash table: insert, search and delete
// requests against a predictor kept in step with the block, under random flow control.
// Depends on lpht_pkg and linear_probe_hash_table from the RTL tree.
`timescale 1ns / 100ps

module testbench;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT      = 500000;
    localparam int DRAIN_GUARD      = 40;
    localparam int PHASE_REQUESTS   = 62;
    localparam int POOL_SIZE        = 24;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT     = 10;

    // Opcode 3 has no meaning in the block; it must answer not found.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Receiver behaviour, changed every so many cycles.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SLUGGISH
    } rx_mode_t;

    // One result as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [HANDLE_W-1:0]   found_handle;
        logic [SLOT_OUT_W-1:0] slot_index;
    } table_answer_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [63:0]         s_tdata;
    logic [OPCODE_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;

    // Predictor copy of the table and its slot count register.
    logic [CFG_W-1:0]    model_slot_count;
    logic [KEY_W-1:0]    model_keys    [TABLE_SLOTS_DEF];
    logic [HANDLE_W-1:0] model_handles [TABLE_SLOTS_DEF];
    mark_t               model_marks   [TABLE_SLOTS_DEF];

    table_answer_t       pending_answers [$];
    table_answer_t       got_answer;
    table_answer_t       want_answer;
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];

    int       burst_left;
    int       requests_sent;
    int       results_seen;
    int       fault_count;
    int       settings_applied;
    int       cycle_count;
    int       status_tally [6];
    int       stall_request;
    int       stall_left;
    int       mode_left;
    int       low_run;
    int       longest_hold;
    rx_mode_t rx_mode;

    linear_probe_hash_table uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Out-of-range slot counts are clamped to 1..TABLE_SLOTS_DEF.
    function automatic int live_slots();
        int n;
        n = int'(model_slot_count);
        if (n < 1) n = 1;
        if (n > TABLE_SLOTS_DEF) n = TABLE_SLOTS_DEF;
        return n;
    endfunction

    function automatic int home_slot(input logic [KEY_W-1:0] key, input int n);
        return int'({1'b0, key} % n);
    endfunction

    // Probe from the home slot; tombstones are stepped over, an empty slot ends the search.
    function automatic bit find_stored_key(input logic [KEY_W-1:0] key, output int where);
        int n;
        int h;
        bit done;
        bit hit;
        n = live_slots();
        h = home_slot(key, n);
        where = 0;
        done = 1'b0;
        hit = 1'b0;
        for (int i = 0; i < n && !done; i++) begin
            if (model_marks[h] == MARK_EMPTY) begin
                done = 1'b1;
            end else if (model_marks[h] == MARK_USED && model_keys[h] == key) begin
                hit = 1'b1;
                done = 1'b1;
                where = h;
            end else begin
                h = (h + 1 == n) ? 0 : h + 1;
            end
        end
        return hit;
    endfunction

    // Works out the answer to one request and updates the predicted table.
    function automatic table_answer_t apply_table_request(input logic [OPCODE_W-1:0] op,
                                                          input logic [KEY_W-1:0] key,
                                                          input logic [HANDLE_W-1:0] handle);
        table_answer_t ans;
        int where;
        int n;
        int h;
        bit hit;
        ans.status = STAT_NOT_FOUND;
        ans.found_handle = '0;
        ans.slot_index = '0;
        hit = find_stored_key(key, where);
        case (op)
            OP_INSERT: begin
                if (hit) begin
                    ans.status = STAT_DUPLICATE;
                    ans.slot_index = where[SLOT_OUT_W-1:0];
                end else begin
                    // Empty and tombstone slots are both free for reuse.
                    n = live_slots();
                    h = home_slot(key, n);
                    ans.status = STAT_FULL;
                    for (int i = 0; i < n && ans.status == STAT_FULL; i++) begin
                        if (model_marks[h] != MARK_USED) begin
                            model_keys[h] = key;
                            model_handles[h] = handle;
                            model_marks[h] = MARK_USED;
                            ans.status = STAT_INSERTED;
                            ans.slot_index = h[SLOT_OUT_W-1:0];
                        end else begin
                            h = (h + 1 == n) ? 0 : h + 1;
                        end
                    end
                end
            end
            OP_SEARCH: begin
                if (hit) begin
                    ans.status = STAT_FOUND;
                    ans.found_handle = model_handles[where];
                    ans.slot_index = where[SLOT_OUT_W-1:0];
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    model_marks[where] = MARK_TOMB;
                    ans.status = STAT_DELETED;
                    ans.slot_index = where[SLOT_OUT_W-1:0];
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Keys are drawn mostly from what is stored and from a small colliding pool, so that
    // hits, duplicates, tombstones and a full table all turn up often.
    function automatic logic [KEY_W-1:0] pick_key(input logic [OPCODE_W-1:0] op);
        int held [$];
        int roll;
        for (int i = 0; i < TABLE_SLOTS_DEF; i++)
            if (model_marks[i] == MARK_USED) held.push_back(i);
        roll = $urandom_range(0, 99);
        if (held.size() != 0 && roll < ((op == OP_INSERT) ? 20 : 55))
            return model_keys[held[$urandom_range(0, held.size() - 1)]];
        if (roll < 93)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return KEY_W'($urandom());
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_opcode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return OP_INSERT;
        if (roll < 70) return OP_SEARCH;
        if (roll < 95) return OP_DELETE;
        return OP_UNUSED;
    endfunction

    function automatic void note_fault(input string what, input logic [31:0] wanted,
                                       input logic [31:0] seen);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what,
                     wanted, seen);
    endfunction

    // Offers one request in bursts with random gaps, and predicts it once accepted.
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [HANDLE_W-1:0] handle);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {1'b0, handle, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_answers.push_back(apply_table_request(op, key, handle));
        requests_sent++;
    endtask

    // Lets every outstanding result come back, then allows the block to settle.
    task automatic wait_until_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_GUARD) @(posedge aclk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        wait_until_idle();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model_slot_count = value;
        settings_applied++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Every operation at the reset slot count: collisions, duplicates, tombstones.
    task automatic test_directed_operations();
        send_request(OP_SEARCH, 31'd0, 32'h0);
        send_request(OP_INSERT, 31'd0, 32'h0);
        send_request(OP_INSERT, 31'd11, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 31'd0, 32'h1234_5678);
        send_request(OP_SEARCH, 31'd11, 32'h0);
        send_request(OP_DELETE, 31'd0, 32'h0);
        send_request(OP_SEARCH, 31'd11, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 31'd0, 32'h0);
        send_request(OP_INSERT, 31'd22, 32'hA5A5_5A5A);
        send_request(OP_INSERT, 31'h7FFF_FFFF, 32'h8000_0001);
        send_request(OP_SEARCH, 31'h7FFF_FFFF, 32'h0);
        send_request(OP_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Slot count of zero acts as one, values above the table act as the table size,
    // and entries left behind become unreachable from their new home slots.
    task automatic test_slot_count_extremes();
        write_slot_count(5'd0);
        send_request(OP_INSERT, 31'd3, 32'h0BAD_F00D);
        send_request(OP_SEARCH, 31'd22, 32'h0);
        send_request(OP_DELETE, 31'd22, 32'h0);
        send_request(OP_INSERT, 31'd3, 32'h0BAD_F00D);
        write_slot_count(5'd31);
        send_request(OP_SEARCH, 31'd3, 32'h0);
        send_request(OP_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_request(OP_DELETE, 31'h7FFF_FFFF, 32'h0);
    endtask

    // Random requests under a series of slot counts, the extremes among them.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] plan [8];
        logic [OPCODE_W-1:0] op;
        plan = '{5'd16, 5'd1, 5'd31, 5'd11, 5'd2, 5'd0, 5'd17, 5'd7};
        plan[7] = CFG_W'($urandom_range(0, 31));
        key_pool[0] = 31'd0;
        key_pool[1] = 31'h7FFF_FFFF;
        key_pool[2] = 31'd16;
        key_pool[3] = 31'd32;
        key_pool[4] = 31'd11;
        key_pool[5] = 31'd22;
        for (int i = 6; i < POOL_SIZE; i++)
            key_pool[i] = (i < 18) ? KEY_W'($urandom_range(0, 63)) : KEY_W'($urandom());
        for (int phase = 0; phase < 8; phase++) begin
            write_slot_count(plan[phase]);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                op = pick_opcode();
                send_request(op, pick_key(op), $urandom());
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming back to back.
    task automatic test_output_backpressure();
        logic [OPCODE_W-1:0] op;
        write_slot_count(5'd16);
        stall_request = LONG_HOLD_CYCLES;
        burst_left = 12;
        for (int i = 0; i < 12; i++) begin
            op = pick_opcode();
            send_request(op, pick_key(op), $urandom());
        end
    endtask

    // Receiver: alternates steady, coin-toss and sluggish stretches, plus one long hold.
    always @(negedge aclk) begin
        if (stall_request != 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left != 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (rx_mode)
                RX_STEADY:   m_tready = 1'b1;
                RX_COIN:     m_tready = ($urandom_range(0, 1) == 1);
                default:     m_tready = ($urandom_range(0, 4) == 0);
            endcase
        end
        low_run = m_tready ? 0 : low_run + 1;
        if (low_run > longest_hold) longest_hold = low_run;
    end

    // Each result is compared with the oldest predicted answer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_answer.status = m_tuser;
            got_answer.found_handle = m_tdata[HANDLE_W-1:0];
            got_answer.slot_index = m_tdata[HANDLE_W +: SLOT_OUT_W];
            results_seen++;
            if (got_answer.status < 6) status_tally[got_answer.status]++;
            if (pending_answers.size() == 0) begin
                note_fault("unrequested result status", '0, 32'(got_answer.status));
            end else begin
                want_answer = pending_answers.pop_front();
                if (got_answer.status != want_answer.status)
                    note_fault("status", 32'(want_answer.status), 32'(got_answer.status));
                if (got_answer.found_handle != want_answer.found_handle)
                    note_fault("found_handle", want_answer.found_handle,
                               got_answer.found_handle);
                if (got_answer.slot_index != want_answer.slot_index)
                    note_fault("slot_index", 32'(want_answer.slot_index),
                               32'(got_answer.slot_index));
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_answers.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_INSERT;
        cfg_valid = 1'b0;
        cfg_data = CFG_RESET;
        model_slot_count = CFG_RESET;
        foreach (model_marks[i]) model_marks[i] = MARK_EMPTY;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_operations();
        test_slot_count_extremes();
        test_random_traffic();
        test_output_backpressure();
        wait_until_idle();

        $display("Sent %0d requests across %0d slot-count settings and compared %0d results;",
                 requests_sent, settings_applied, results_seen);
        $display("statuses %0d/%0d/%0d/%0d/%0d/%0d (ins/found/miss/dup/full/del), %s %0d cycles.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4], status_tally[5], "longest output hold", longest_hold);
        if (fault_count == 0 && pending_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
